[src/spdm_pkg.sv]
// Shared types and constants for the signal pending/mask delivery block.
package spdm_pkg;

	// Highest signal number in use; signals are numbered 1..MAX_SIGNAL
	localparam int MAX_SIGNAL = 63;

	// Width of a signal number and of every signal set
	localparam int SIG_W  = 6;
	localparam int NSIG   = 64;
	localparam int MASK_W = 64;

	// Bits that stand for real signals
	localparam logic [MASK_W-1:0] SIG_MASK =
		(((MASK_W'(1) << MAX_SIGNAL) << 1) - MASK_W'(2));

	// Request codes
	typedef enum logic [2:0] {
		REQ_POST    = 3'd0,
		REQ_DELIVER = 3'd1,
		REQ_MASK    = 3'd2,
		REQ_ACTION  = 3'd3,
		REQ_QUERY   = 3'd4,
		REQ_RETURN  = 3'd5,
		REQ_EXEC    = 3'd6
	} req_kind_t;

	// Blocked set update modes
	typedef enum logic [1:0] {
		HOW_BLOCK   = 2'd0,
		HOW_UNBLOCK = 2'd1,
		HOW_SET     = 2'd2,
		HOW_BAD     = 2'd3
	} how_t;

	// Dispositions
	typedef enum logic [1:0] {
		ACT_DEFAULT = 2'd0,
		ACT_IGNORE  = 2'd1,
		ACT_HANDLER = 2'd2,
		ACT_BAD     = 2'd3
	} act_t;

	// Verdicts
	typedef enum logic [1:0] {
		VERD_NONE    = 2'd0,
		VERD_KILL    = 2'd1,
		VERD_HANDLER = 2'd2
	} verdict_t;

	// Controller states
	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	// Configuration register indexes
	localparam logic CFG_KILL = 1'b0;
	localparam logic CFG_STOP = 1'b1;

	// Outcome of the delivery priority pick
	typedef struct packed {
		logic              found;
		logic [SIG_W-1:0]  sig;
		logic [MASK_W-1:0] clear;
	} pick_t;

	// Termination code: minus ten minus the signal
	function automatic logic signed [7:0] exit_for(input logic [SIG_W-1:0] s);
		exit_for = 8'(8'd0 - (8'd10 + 8'(s)));
	endfunction

endpackage

[src/spdm_ram.sv]
// Generic single-port-write, registered-read RAM.
module spdm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[src/spdm_pick.sv]
// Delivery priority pick: lowest pending, unblocked, non-ignored signal.
module spdm_pick (
	input  logic [spdm_pkg::MASK_W-1:0] pending,
	input  logic [spdm_pkg::MASK_W-1:0] blocked,
	input  logic [spdm_pkg::MASK_W-1:0] ignore_set,
	output spdm_pkg::pick_t             pick
);

	logic [spdm_pkg::MASK_W-1:0] cand;
	logic [spdm_pkg::MASK_W-1:0] live;
	logic [spdm_pkg::MASK_W-1:0] low;
	logic [spdm_pkg::MASK_W-1:0] upto;
	logic [spdm_pkg::SIG_W-1:0]  idx;

	// candidates, then isolate the lowest deliverable one
	assign cand = pending & ~blocked & spdm_pkg::SIG_MASK;
	assign live = cand & ~ignore_set;
	assign low  = live & (~live + spdm_pkg::MASK_W'(1));
	// everything up to and including the pick; all ones when nothing found
	assign upto = low | (low - spdm_pkg::MASK_W'(1));

	// one-hot to index
	always_comb begin
		idx = '0;
		for (int i = 0; i < spdm_pkg::NSIG; i++) begin
			if (low[i]) begin
				idx = idx | spdm_pkg::SIG_W'(i);
			end
		end
	end

	assign pick.found = (live != '0);
	assign pick.sig   = idx;
	// ignored signals below the pick leave pending along with it
	assign pick.clear = cand & upto;

endmodule

[src/signal_pending_mask_delivery_core.sv]
// Per-process signal unit: pending/blocked sets, dispositions, handler masks.
//
// A request is handled in an accept cycle, in which the delivery pick is
// made and the handler mask memory is read, and then in an execute cycle in
// which the memory word arrives, the bit sets are updated and the result
// word is loaded into the output register. The 64-entry handler mask memory
// has a registered read port, so its word arrives in the execute cycle. A
// result waiting in the output register does not stop the next request
// being accepted; only the execute cycle waits until the output register
// is free. Handler masks are tracked by per-signal live bits, so there is no
// clearing pass after reset and requests are accepted straight away.
module signal_pending_mask_delivery_core (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration
	input  logic                               cfg_write,
	input  logic                               cfg_index,
	input  logic [spdm_pkg::SIG_W-1:0]         cfg_data,
	// request channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [2:0]                         req_type,
	input  logic [spdm_pkg::SIG_W-1:0]         signal_number,
	input  logic [1:0]                         mask_how,
	input  logic [spdm_pkg::MASK_W-1:0]        mask_value,
	input  logic [1:0]                         action_kind,
	input  logic [spdm_pkg::MASK_W-1:0]        action_mask,
	input  logic                               action_write,
	// result channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               status,
	output logic [1:0]                         verdict,
	output logic [spdm_pkg::SIG_W-1:0]         signal_out,
	output logic signed [7:0]                  exit_code,
	output logic [spdm_pkg::MASK_W-1:0]        mask_out,
	output logic [1:0]                         old_action_kind,
	output logic [spdm_pkg::MASK_W-1:0]        old_action_mask
);

	localparam int MW = spdm_pkg::MASK_W;
	localparam int SW = spdm_pkg::SIG_W;

	// configuration registers
	logic [SW-1:0] kill_q, stop_q;

	// bit sets
	logic [MW-1:0] pend_q, blk_q, ign_q, hnd_q, live_q;
	logic [MW-1:0] pend_n, blk_n, ign_n, hnd_n, live_n;

	// control
	spdm_pkg::state_t state_q, state_n;
	logic             in_acc, do_exec;

	// accepted request word
	logic [2:0]      req_s1;
	logic [SW-1:0]   sig_s1;
	logic [1:0]      how_s1;
	logic [MW-1:0]   mval_s1;
	logic [1:0]      kind_s1;
	logic [MW-1:0]   amask_s1;
	logic            awrite_s1;
	spdm_pkg::pick_t pick, pick_s1;

	// memory interface
	logic [SW-1:0] raddr;
	logic [MW-1:0] rdata;
	logic          ram_we;

	// execute results
	logic                 status_n;
	logic [1:0]           verdict_n, okind_n;
	logic [SW-1:0]        sigout_n, tsig;
	logic signed [7:0]    code_n;
	logic [MW-1:0]        mout_n, omask_n, tbit, hmask;
	logic                 sig_ok, sig_prot;

	// result register
	logic                 out_valid_q;
	logic                 status_q;
	logic [1:0]           verdict_q, okind_q;
	logic [SW-1:0]        sigout_q;
	logic signed [7:0]    code_q;
	logic [MW-1:0]        mout_q, omask_q;

	// priority pick on the current sets
	spdm_pick u_pick (
		.pending    (pend_q),
		.blocked    (blk_q),
		.ignore_set (ign_q),
		.pick       (pick)
	);

	// handler mask memory
	assign raddr = (req_type == spdm_pkg::REQ_DELIVER) ? pick.sig : signal_number;

	spdm_ram #(
		.WIDTH (MW),
		.DEPTH (spdm_pkg::NSIG)
	) u_mask_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (sig_s1),
		.wdata (amask_s1),
		.re    (in_acc),
		.raddr (raddr),
		.rdata (rdata)
	);

	// controller
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spdm_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n  = state_q;
		in_stall = 1'b1;
		in_acc   = 1'b0;
		do_exec  = 1'b0;
		unique case (state_q)
			spdm_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				in_acc   = in_valid;
				if (in_valid) begin
					state_n = spdm_pkg::ST_EXEC;
				end
			end
			spdm_pkg::ST_EXEC: begin
				if (!out_valid_q || !out_stall) begin
					do_exec = 1'b1;
					state_n = spdm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_n = spdm_pkg::ST_IDLE;
			end
		endcase
	end

	// capture the request word and the pick
	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_s1    <= req_type;
			sig_s1    <= signal_number;
			how_s1    <= mask_how;
			mval_s1   <= mask_value;
			kind_s1   <= action_kind;
			amask_s1  <= action_mask;
			awrite_s1 <= action_write;
			pick_s1   <= pick;
		end
	end

	// execute: read-modify-write of the sets and the result word
	assign tsig     = (req_s1 == spdm_pkg::REQ_DELIVER) ? pick_s1.sig : sig_s1;
	assign tbit     = MW'(1) << tsig;
	assign hmask    = live_q[tsig] ? rdata : '0;
	assign sig_ok   = (sig_s1 != '0) && (int'(sig_s1) <= spdm_pkg::MAX_SIGNAL);
	assign sig_prot = (sig_s1 == kill_q) || (sig_s1 == stop_q);

	always_comb begin
		pend_n    = pend_q;
		blk_n     = blk_q;
		ign_n     = ign_q;
		hnd_n     = hnd_q;
		live_n    = live_q;
		ram_we    = 1'b0;
		status_n  = 1'b0;
		verdict_n = spdm_pkg::VERD_NONE;
		sigout_n  = '0;
		code_n    = '0;
		mout_n    = '0;
		okind_n   = spdm_pkg::ACT_DEFAULT;
		omask_n   = '0;
		unique case (req_s1)
			spdm_pkg::REQ_POST: begin
				if (!sig_ok) begin
					status_n = 1'b1;
				end else if (sig_prot) begin
					verdict_n = spdm_pkg::VERD_KILL;
					sigout_n  = sig_s1;
					code_n    = spdm_pkg::exit_for(sig_s1);
				end else begin
					pend_n = pend_q | tbit;
				end
			end
			spdm_pkg::REQ_DELIVER: begin
				pend_n = pend_q & ~pick_s1.clear;
				if (pick_s1.found) begin
					sigout_n = pick_s1.sig;
					if (hnd_q[pick_s1.sig]) begin
						verdict_n = spdm_pkg::VERD_HANDLER;
						mout_n    = blk_q;
						blk_n     = blk_q | hmask | tbit;
					end else begin
						verdict_n = spdm_pkg::VERD_KILL;
						code_n    = spdm_pkg::exit_for(pick_s1.sig);
					end
				end
			end
			spdm_pkg::REQ_MASK: begin
				mout_n = blk_q;
				unique case (how_s1)
					spdm_pkg::HOW_BLOCK:   blk_n = blk_q | mval_s1;
					spdm_pkg::HOW_UNBLOCK: blk_n = blk_q & ~mval_s1;
					spdm_pkg::HOW_SET:     blk_n = mval_s1;
					default:               status_n = 1'b1;
				endcase
			end
			spdm_pkg::REQ_ACTION: begin
				if (!sig_ok || sig_prot) begin
					status_n = 1'b1;
				end else begin
					okind_n = hnd_q[sig_s1] ? spdm_pkg::ACT_HANDLER :
						(ign_q[sig_s1] ? spdm_pkg::ACT_IGNORE : spdm_pkg::ACT_DEFAULT);
					omask_n = hmask;
					if (awrite_s1) begin
						if (kind_s1 == spdm_pkg::ACT_BAD) begin
							status_n = 1'b1;
						end else begin
							ign_n  = (kind_s1 == spdm_pkg::ACT_IGNORE) ?
								(ign_q | tbit) : (ign_q & ~tbit);
							hnd_n  = (kind_s1 == spdm_pkg::ACT_HANDLER) ?
								(hnd_q | tbit) : (hnd_q & ~tbit);
							live_n = live_q | tbit;
							ram_we = do_exec;
						end
					end
				end
			end
			spdm_pkg::REQ_QUERY: begin
				mout_n = pend_q & blk_q;
			end
			spdm_pkg::REQ_RETURN: begin
				blk_n = mval_s1;
			end
			spdm_pkg::REQ_EXEC: begin
				hnd_n  = '0;
				live_n = live_q & ign_q;
			end
			default: begin
				status_n = 1'b1;
			end
		endcase
	end

	// configuration and bit set registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kill_q <= SW'(9);
			stop_q <= SW'(19);
			pend_q <= '0;
			blk_q  <= '0;
			ign_q  <= '0;
			hnd_q  <= '0;
			live_q <= '0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					spdm_pkg::CFG_KILL: kill_q <= cfg_data;
					spdm_pkg::CFG_STOP: stop_q <= cfg_data;
					default:            ;
				endcase
			end
			if (do_exec) begin
				pend_q <= pend_n;
				blk_q  <= blk_n;
				ign_q  <= ign_n;
				hnd_q  <= hnd_n;
				live_q <= live_n;
			end
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_exec) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (do_exec) begin
			status_q  <= status_n;
			verdict_q <= verdict_n;
			sigout_q  <= sigout_n;
			code_q    <= code_n;
			mout_q    <= mout_n;
			okind_q   <= okind_n;
			omask_q   <= omask_n;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign verdict         = verdict_q;
	assign signal_out      = sigout_q;
	assign exit_code       = code_q;
	assign mask_out        = mout_q;
	assign old_action_kind = okind_q;
	assign old_action_mask = omask_q;

endmodule
